>>> hw/rtl/ang_pkg.sv
// ----------------------------------------------------------------------------
// ang_pkg
// Shared types and constants of the audio noise gate: sample and gain
// formats, register indexes and reset values, and the queue entry layouts.
// ----------------------------------------------------------------------------
package ang_pkg;

   localparam int MAX_CHANNELS   = 8;
   localparam int SAMPLE_BITS    = 24;
   localparam int GAIN_FRAC_BITS = 16;
   localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
   localparam int LEVEL_BITS     = SAMPLE_BITS + 1;
   localparam int HOLD_BITS      = 20;
   localparam int CH_BITS        = 4;
   localparam int STEP_BITS      = 17;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;

   localparam logic [GAIN_BITS-1:0] UNITY    = GAIN_BITS'(1 << GAIN_FRAC_BITS);
   localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ACTIVE_CHANNELS = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_OPEN_LIMIT      = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CLOSE_LIMIT     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DECAY_STEP      = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ATTACK_STEP     = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RELEASE_STEP    = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HOLD_FRAMES     = 3'd6;

   localparam logic [CH_BITS-1:0]     RST_ACTIVE_CHANNELS = 4'd2;
   localparam logic [SAMPLE_BITS-1:0] RST_OPEN_LIMIT      = 24'd420430;
   localparam logic [SAMPLE_BITS-1:0] RST_CLOSE_LIMIT     = 24'd210715;
   localparam logic [SAMPLE_BITS-1:0] RST_DECAY_STEP      = 24'd328;
   localparam logic [STEP_BITS-1:0]   RST_ATTACK_STEP     = 17'd55;
   localparam logic [STEP_BITS-1:0]   RST_RELEASE_STEP    = 17'd9;
   localparam logic [HOLD_BITS-1:0]   RST_HOLD_FRAMES     = 20'd9600;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [MAX_CHANNELS-1:0] frame_type;

   typedef struct packed {
      logic [CH_BITS-1:0]     active_channels;
      logic [SAMPLE_BITS-1:0] open_limit;
      logic [SAMPLE_BITS-1:0] close_limit;
      logic [SAMPLE_BITS-1:0] decay_step;
      logic [STEP_BITS-1:0]   attack_step;
      logic [STEP_BITS-1:0]   release_step;
      logic [HOLD_BITS-1:0]   hold_frames;
   } cfg_type;

   typedef struct packed {
      frame_type            samples;
      logic [GAIN_BITS-1:0] gain;
      logic                 gate_open;
   } mid_type;

   typedef struct packed {
      frame_type outs;
      logic      gate_open;
   } rsp_type;

endpackage

>>> hw/rtl/ang_fifo.sv
// ----------------------------------------------------------------------------
// ang_fifo
// Small show-ahead queue: the oldest entry is on rdata while empty is low.
// ----------------------------------------------------------------------------
module ang_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> hw/rtl/ang_front.sv
// ----------------------------------------------------------------------------
// ang_front
// Front end: takes frames, finds the peak magnitude over the active
// channels and advances the gate state, level, hold count and gain.
// ----------------------------------------------------------------------------
module ang_front (
   input  logic              clock,
   input  logic              reset,
   input  ang_pkg::cfg_type  cfg,
   input  logic              req_push,
   output logic              req_full,
   input  ang_pkg::frame_type req_frame,
   output logic              mid_push,
   output ang_pkg::mid_type  mid_wdata,
   input  logic              mid_full
);
   import ang_pkg::*;

   logic                   adv;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] mag_in [MAX_CHANNELS];
   logic [SAMPLE_BITS-1:0] peak_in;

   logic                   s1_valid_ff;
   frame_type              s1_frame_ff;
   logic [SAMPLE_BITS-1:0] s1_mag_ff [MAX_CHANNELS];
   logic                   s2_valid_ff;
   frame_type              s2_frame_ff;
   logic [SAMPLE_BITS-1:0] s2_peak_ff;

   logic                         gate_ff, gate_in;
   logic signed [LEVEL_BITS-1:0] held_ff, held_in;
   logic [GAIN_BITS-1:0]         gain_ff, gain_in;
   logic [HOLD_BITS-1:0]         hold_ff, hold_in;

   logic                         opened;
   logic                         closing;
   logic signed [LEVEL_BITS-1:0] peak_s;
   logic signed [LEVEL_BITS-1:0] top;
   logic [GAIN_BITS:0]           gain_sum;
   logic [HOLD_BITS-1:0]         hold_base;
   logic [HOLD_BITS-1:0]         hold_inc;

   assign adv      = !(s2_valid_ff && mid_full);
   assign req_full = !adv;
   assign accept   = req_push && adv;
   assign mid_push = s2_valid_ff && adv;

   // channel 0 always feeds the peak
   always_comb begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         if (k == 0 || CH_BITS'(k) < cfg.active_channels) begin
            mag_in[k] = req_frame[k][SAMPLE_BITS-1] ? SAMPLE_BITS'(-req_frame[k])
                                                     : SAMPLE_BITS'(req_frame[k]);
         end else begin
            mag_in[k] = '0;
         end
      end
   end

   always_comb begin
      peak_in = s1_mag_ff[0];
      for (int k = 1; k < MAX_CHANNELS; k++) begin
         if (s1_mag_ff[k] > peak_in) begin
            peak_in = s1_mag_ff[k];
         end
      end
   end

   always_comb begin
      opened   = gate_ff || (s2_peak_ff > cfg.open_limit);
      closing  = opened && (held_ff < $signed({1'b0, cfg.close_limit}));
      gate_in  = opened && !closing;

      peak_s   = $signed({1'b0, s2_peak_ff});
      top      = (held_ff > peak_s) ? held_ff : peak_s;
      held_in  = top - $signed({1'b0, cfg.decay_step});

      gain_sum  = {1'b0, gain_ff} + {1'b0, cfg.attack_step};
      hold_base = closing ? '0 : hold_ff;
      hold_inc  = (hold_base == HOLD_MAX) ? hold_base : hold_base + 1'b1;

      gain_in = gain_ff;
      hold_in = hold_ff;
      if (gate_in) begin
         gain_in = (gain_sum > {1'b0, UNITY}) ? UNITY : gain_sum[GAIN_BITS-1:0];
      end else begin
         hold_in = hold_inc;
         if (hold_inc > cfg.hold_frames) begin
            gain_in = (gain_ff > cfg.release_step) ? gain_ff - cfg.release_step : '0;
         end
      end
   end

   assign mid_wdata.samples   = s2_frame_ff;
   assign mid_wdata.gain      = gain_in;
   assign mid_wdata.gate_open = gate_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         gate_ff     <= 1'b0;
         held_ff     <= '0;
         gain_ff     <= '0;
         hold_ff     <= '0;
      end else begin
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
         end
         if (mid_push) begin
            gate_ff <= gate_in;
            held_ff <= held_in;
            gain_ff <= gain_in;
            hold_ff <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_frame_ff <= req_frame;
         s1_mag_ff   <= mag_in;
         s2_frame_ff <= s1_frame_ff;
         s2_peak_ff  <= peak_in;
      end
   end

endmodule

>>> hw/rtl/ang_back.sv
// ----------------------------------------------------------------------------
// ang_back
// Back end: applies the frame's gain to every channel, floors the scaled
// products and zeroes the inactive channels.
// ----------------------------------------------------------------------------
module ang_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ang_pkg::CH_BITS-1:0]   active_channels,
   input  logic                          mid_empty,
   output logic                          mid_pop,
   input  ang_pkg::mid_type              mid_rdata,
   input  logic                          out_full,
   output logic                          out_push,
   output ang_pkg::rsp_type              out_wdata
);
   import ang_pkg::*;

   logic                        m_valid_ff;
   logic signed [PROD_BITS-1:0] prod_ff [MAX_CHANNELS];
   logic                        gate_ff;

   assign out_push = m_valid_ff && !out_full;
   assign mid_pop  = !mid_empty && (!m_valid_ff || !out_full);

   always_comb begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         if (CH_BITS'(k) < active_channels) begin
            out_wdata.outs[k] = prod_ff[k][GAIN_FRAC_BITS +: SAMPLE_BITS];
         end else begin
            out_wdata.outs[k] = '0;
         end
      end
      out_wdata.gate_open = gate_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (mid_pop) begin
         m_valid_ff <= 1'b1;
      end else if (out_push) begin
         m_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            prod_ff[k] <= $signed(mid_rdata.samples[k]) * $signed({1'b0, mid_rdata.gain});
         end
         gate_ff <= mid_rdata.gate_open;
      end
   end

endmodule

>>> hw/rtl/audio_noise_gate.sv
// ----------------------------------------------------------------------------
// audio_noise_gate
// Multichannel noise gate with attack, hold and release. A front end
// finds the frame peak and updates the gate state and gain, a queue
// decouples it from a back end that scales the samples.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+--------------------------
//   request | req_sample_0..7               | req_push / req_full
//   result  | rsp_out_0..7, rsp_gate_is_open| rsp_empty / rsp_pop
//   config  | csr_index, csr_wdata          | csr_wr_en
//
// One frame per cycle sustained while the result side keeps up; the gate
// state update is a loop through its own registers in the front end.
// Synchronous reset clears the queues, the gate state and the registers
// to their defaults. A stalled result side fills the output queue, then
// the middle queue, then raises req_full.
// ----------------------------------------------------------------------------
module audio_noise_gate #(
   parameter int MID_DEPTH = 2,
   parameter int OUT_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_0,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_1,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_2,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_3,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_4,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_5,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_6,
   input  logic signed [ang_pkg::SAMPLE_BITS-1:0] req_sample_7,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_0,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_1,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_2,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_3,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_4,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_5,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_6,
   output logic signed [ang_pkg::SAMPLE_BITS-1:0] rsp_out_7,
   output logic                                rsp_gate_is_open,
   input  logic                                csr_wr_en,
   input  logic [ang_pkg::CSR_ADDR_BITS-1:0]   csr_index,
   input  logic [ang_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ang_pkg::*;

   cfg_type   cfg_ff;
   frame_type req_frame;
   logic      mid_push, mid_full, mid_pop, mid_empty;
   mid_type   mid_wdata, mid_rdata;
   logic      out_push, out_full;
   rsp_type   out_wdata, out_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_channels <= RST_ACTIVE_CHANNELS;
         cfg_ff.open_limit      <= RST_OPEN_LIMIT;
         cfg_ff.close_limit     <= RST_CLOSE_LIMIT;
         cfg_ff.decay_step      <= RST_DECAY_STEP;
         cfg_ff.attack_step     <= RST_ATTACK_STEP;
         cfg_ff.release_step    <= RST_RELEASE_STEP;
         cfg_ff.hold_frames     <= RST_HOLD_FRAMES;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACTIVE_CHANNELS: cfg_ff.active_channels <= csr_wdata[CH_BITS-1:0];
            CSR_OPEN_LIMIT:      cfg_ff.open_limit      <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_CLOSE_LIMIT:     cfg_ff.close_limit     <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_DECAY_STEP:      cfg_ff.decay_step      <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_ATTACK_STEP:     cfg_ff.attack_step     <= csr_wdata[STEP_BITS-1:0];
            CSR_RELEASE_STEP:    cfg_ff.release_step    <= csr_wdata[STEP_BITS-1:0];
            CSR_HOLD_FRAMES:     cfg_ff.hold_frames     <= csr_wdata[HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_frame[0] = req_sample_0;
   assign req_frame[1] = req_sample_1;
   assign req_frame[2] = req_sample_2;
   assign req_frame[3] = req_sample_3;
   assign req_frame[4] = req_sample_4;
   assign req_frame[5] = req_sample_5;
   assign req_frame[6] = req_sample_6;
   assign req_frame[7] = req_sample_7;

   ang_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_frame (req_frame),
      .mid_push  (mid_push),
      .mid_wdata (mid_wdata),
      .mid_full  (mid_full)
   );

   ang_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   ang_back u_back (
      .clock           (clock),
      .reset           (reset),
      .active_channels (cfg_ff.active_channels),
      .mid_empty       (mid_empty),
      .mid_pop         (mid_pop),
      .mid_rdata       (mid_rdata),
      .out_full        (out_full),
      .out_push        (out_push),
      .out_wdata       (out_wdata)
   );

   ang_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_out_0        = out_rdata.outs[0];
   assign rsp_out_1        = out_rdata.outs[1];
   assign rsp_out_2        = out_rdata.outs[2];
   assign rsp_out_3        = out_rdata.outs[3];
   assign rsp_out_4        = out_rdata.outs[4];
   assign rsp_out_5        = out_rdata.outs[5];
   assign rsp_out_6        = out_rdata.outs[6];
   assign rsp_out_7        = out_rdata.outs[7];
   assign rsp_gate_is_open = out_rdata.gate_open;

   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full)
      else $error("request pushed into full middle queue");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("request pushed into full output queue");

   a_gain_limit: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> (mid_wdata.gain <= UNITY))
      else $error("gain above unity");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending after reset");

endmodule
